// ===== hw/rtl/sgt_pkg.sv =====
// ----------------------------------------------------------------------------
// sgt_pkg: swipe gesture tracker shared definitions
// Event codes, swipe directions, register widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sgt_pkg;

    localparam int COORD_BITS_DEF = 15;
    localparam int OP_W           = 2;
    localparam int DIR_W          = 3;
    localparam int MIN_DIST_W     = 12;
    localparam int TAN_W          = 16;
    localparam int TAN_FRAC       = 14;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 1;

    localparam logic [MIN_DIST_W-1:0] MIN_DIST_RST = 12'd16;
    localparam logic [TAN_W-1:0]      TAN_RST      = 16'd11472;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN      = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_DOWN = 2'd0,
        OP_MOVE = 2'd1,
        OP_UP   = 2'd2
    } t_op;

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4
    } t_dir;

    typedef struct packed {
        logic far;
        t_dir dir;
    } t_eval;

endpackage

`default_nettype wire

// ===== hw/rtl/swipe_gesture_tracker.sv =====
// ----------------------------------------------------------------------------
// swipe_gesture_tracker: pointer swipe and drag detection
// Tracks press, drag and release marks and classifies the swipe on release.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_opcode, i_pos_x, i_pos_y
//   out      output     o_out_valid / i_out_ready o_swipe_dir, o_is_pressed,
//                                                 o_is_dragging, o_is_released
//   cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item per cycle sustained while i_out_ready stays high; an accepted item
// passes the input register, then the geometry into the result register.
// The result registers are the gesture state itself, so a pending result
// holds the input register, which in turn holds o_in_ready low.
// Reset clears marks, valids and restores register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module swipe_gesture_tracker #(
    parameter int COORD_BITS = sgt_pkg::COORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [sgt_pkg::OP_W-1:0]         i_opcode,
    input  wire logic signed [COORD_BITS-1:0]     i_pos_x,
    input  wire logic signed [COORD_BITS-1:0]     i_pos_y,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [sgt_pkg::DIR_W-1:0]             o_swipe_dir,
    output logic                                  o_is_pressed,
    output logic                                  o_is_dragging,
    output logic                                  o_is_released,
    input  wire logic                             i_cfg_we,
    input  wire logic [sgt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sgt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [sgt_pkg::MIN_DIST_W-1:0]  r_min_dist;
    logic [sgt_pkg::TAN_W-1:0]       r_tan;

    logic                            r_in_valid;
    logic [sgt_pkg::OP_W-1:0]        r_op;
    logic signed [COORD_BITS-1:0]    r_pos_x;
    logic signed [COORD_BITS-1:0]    r_pos_y;

    logic                            r_out_valid;
    logic                            r_pressed;
    logic                            r_dragging;
    logic                            r_released;
    sgt_pkg::t_dir                   r_swipe;
    logic signed [COORD_BITS-1:0]    r_start_x;
    logic signed [COORD_BITS-1:0]    r_start_y;

    logic                            n_pressed;
    logic                            n_dragging;
    logic                            n_released;
    sgt_pkg::t_dir                   n_swipe;
    logic                            n_load_start;

    logic                            advance;
    sgt_pkg::t_eval                  eval;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    sgt_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .i_pos_x    (r_pos_x),
        .i_pos_y    (r_pos_y),
        .i_start_x  (r_start_x),
        .i_start_y  (r_start_y),
        .i_min_dist (r_min_dist),
        .i_tan      (r_tan),
        .o_eval     (eval)
    );

    always_comb begin
        n_pressed    = r_pressed;
        n_dragging   = r_dragging;
        n_released   = r_released;
        n_swipe      = r_swipe;
        n_load_start = 1'b0;
        case (r_op)
            sgt_pkg::OP_DOWN: begin
                n_pressed    = 1'b1;
                n_dragging   = 1'b0;
                n_released   = 1'b0;
                n_swipe      = sgt_pkg::DIR_NONE;
                n_load_start = 1'b1;
            end
            sgt_pkg::OP_MOVE: begin
                if (r_pressed && eval.far) begin
                    n_dragging = 1'b1;
                end
            end
            sgt_pkg::OP_UP: begin
                if (r_pressed) begin
                    n_dragging = r_dragging || eval.far;
                    n_swipe    = eval.dir;
                    n_pressed  = 1'b0;
                    n_released = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= sgt_pkg::MIN_DIST_RST;
            r_tan      <= sgt_pkg::TAN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sgt_pkg::CFG_MIN_DIST: r_min_dist <= i_cfg_data[sgt_pkg::MIN_DIST_W-1:0];
                sgt_pkg::CFG_TAN:      r_tan      <= i_cfg_data[sgt_pkg::TAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op    <= i_opcode;
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
        end
    end

    // gesture state, doubling as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pressed   <= 1'b0;
            r_dragging  <= 1'b0;
            r_released  <= 1'b0;
            r_swipe     <= sgt_pkg::DIR_NONE;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_pressed   <= n_pressed;
                r_dragging  <= n_dragging;
                r_released  <= n_released;
                r_swipe     <= n_swipe;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_load_start) begin
            r_start_x <= r_pos_x;
            r_start_y <= r_pos_y;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_swipe_dir   = r_swipe;
    assign o_is_pressed  = r_pressed;
    assign o_is_dragging = r_dragging;
    assign o_is_released = r_released;

endmodule

`default_nettype wire

// ===== hw/rtl/sgt_eval.sv =====
// ----------------------------------------------------------------------------
// sgt_eval: gesture geometry
// Distance test and swipe classification of one position against the start.
// ----------------------------------------------------------------------------
`default_nettype none

module sgt_eval #(
    parameter int COORD_BITS = sgt_pkg::COORD_BITS_DEF
) (
    input  wire logic signed [COORD_BITS-1:0]          i_pos_x,
    input  wire logic signed [COORD_BITS-1:0]          i_pos_y,
    input  wire logic signed [COORD_BITS-1:0]          i_start_x,
    input  wire logic signed [COORD_BITS-1:0]          i_start_y,
    input  wire logic        [sgt_pkg::MIN_DIST_W-1:0] i_min_dist,
    input  wire logic        [sgt_pkg::TAN_W-1:0]      i_tan,
    output sgt_pkg::t_eval                             o_eval
);

    localparam int DW   = COORD_BITS + 1;
    localparam int SQ_W = 2 * DW;
    localparam int D2_W = (SQ_W + 1 > 2 * sgt_pkg::MIN_DIST_W) ?
                          SQ_W + 1 : 2 * sgt_pkg::MIN_DIST_W;
    localparam int A_W  = DW + sgt_pkg::TAN_W;

    logic signed [DW-1:0]                      dx;
    logic signed [DW-1:0]                      dy;
    logic        [DW-1:0]                      ax;
    logic        [DW-1:0]                      ay;
    logic        [SQ_W-1:0]                    sq_x;
    logic        [SQ_W-1:0]                    sq_y;
    logic        [D2_W-1:0]                    d2;
    logic        [2*sgt_pkg::MIN_DIST_W-1:0]   m2;
    logic        [A_W-1:0]                     ax_sh;
    logic        [A_W-1:0]                     ay_sh;
    logic        [A_W-1:0]                     ax_tan;
    logic        [A_W-1:0]                     ay_tan;
    logic                                      far;
    logic                                      h_ok;
    logic                                      v_ok;

    assign dx = DW'(i_pos_x) - DW'(i_start_x);
    assign dy = DW'(i_pos_y) - DW'(i_start_y);

    assign ax = dx[DW-1] ? unsigned'(-dx) : unsigned'(dx);
    assign ay = dy[DW-1] ? unsigned'(-dy) : unsigned'(dy);

    assign sq_x = SQ_W'(ax) * SQ_W'(ax);
    assign sq_y = SQ_W'(ay) * SQ_W'(ay);
    assign d2   = D2_W'(sq_x) + D2_W'(sq_y);
    assign m2   = (2*sgt_pkg::MIN_DIST_W)'(i_min_dist) * (2*sgt_pkg::MIN_DIST_W)'(i_min_dist);
    assign far  = d2 >= D2_W'(m2);

    assign ax_sh  = A_W'({ax, {sgt_pkg::TAN_FRAC{1'b0}}});
    assign ay_sh  = A_W'({ay, {sgt_pkg::TAN_FRAC{1'b0}}});
    assign ax_tan = A_W'(ax) * A_W'(i_tan);
    assign ay_tan = A_W'(ay) * A_W'(i_tan);
    assign h_ok   = ay_sh <= ax_tan;
    assign v_ok   = ax_sh <= ay_tan;

    always_comb begin
        o_eval.far = far;
        if (!far) begin
            o_eval.dir = sgt_pkg::DIR_NONE;
        end else if (h_ok) begin
            o_eval.dir = dx[DW-1] ? sgt_pkg::DIR_LEFT : sgt_pkg::DIR_RIGHT;
        end else if (v_ok) begin
            o_eval.dir = dy[DW-1] ? sgt_pkg::DIR_UP : sgt_pkg::DIR_DOWN;
        end else begin
            o_eval.dir = sgt_pkg::DIR_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_swipe_gesture_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_swipe_gesture_tracker: self-checking testbench for the swipe tracker
// Drives pointer down, move and up items through the valid/ready input,
// predicts each untyped result from a model of the gesture marks kept here (typed table rows
// carry their own), and checks each result field by field. A directed table comes first,
// then random gestures under several register settings with random stalls in all but one phase.
// ----------------------------------------------------------------------------

module tb_swipe_gesture_tracker;

    import sgt_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int NUM_PHASES = 10;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        t_dir dir;
        logic pressed;
        logic dragging;
        logic released;
    } gesture_marks_t;

    localparam gesture_marks_t MARKS_IDLE   = gesture_marks_t'{DIR_NONE, 1'b0, 1'b0, 1'b0};
    localparam gesture_marks_t MARKS_HELD   = gesture_marks_t'{DIR_NONE, 1'b1, 1'b0, 1'b0};
    localparam gesture_marks_t MARKS_LIFTED = gesture_marks_t'{DIR_NONE, 1'b0, 1'b0, 1'b1};

    typedef struct {
        logic                  is_reg;
        logic [OP_W-1:0]       op;
        coord_t                x;
        coord_t                y;
        logic                  typed;
        gesture_marks_t        want;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
    } stim_row_t;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_opcode      = '0;
    coord_t                i_pos_x       = '0;
    coord_t                i_pos_y       = '0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic [DIR_W-1:0]      o_swipe_dir;
    logic                  o_is_pressed;
    logic                  o_is_dragging;
    logic                  o_is_released;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic [MIN_DIST_W-1:0] trk_min_dist  = MIN_DIST_RST;
    logic [TAN_W-1:0]      trk_tan       = TAN_RST;
    logic                  trk_pressed   = 1'b0;
    logic                  trk_dragging  = 1'b0;
    logic                  trk_released  = 1'b0;
    t_dir                  trk_dir       = DIR_NONE;
    coord_t                trk_start_x   = '0;
    coord_t                trk_start_y   = '0;

    gesture_marks_t pending_marks[$];
    stim_row_t      directed_rows[$];
    logic           stall_on     = 1'b1;
    int             errors       = 0;
    int             sent_items   = 0;
    int             live_items   = 0;
    int             cfg_writes   = 0;
    int             swipe_count[5];

    swipe_gesture_tracker #(
        .COORD_BITS(CW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_swipe_dir  (o_swipe_dir),
        .o_is_pressed (o_is_pressed),
        .o_is_dragging(o_is_dragging),
        .o_is_released(o_is_released),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Timeout at %0t with %0d results outstanding", $time, pending_marks.size());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic gesture_marks_t track_gesture(logic [OP_W-1:0] op, coord_t x, coord_t y);
        longint dx, dy, ax, ay;
        logic reach;
        gesture_marks_t marks;
        dx = longint'(x) - longint'(trk_start_x);
        dy = longint'(y) - longint'(trk_start_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        reach = (ax * ax + ay * ay) >= longint'(trk_min_dist) * longint'(trk_min_dist);
        if (op == OP_DOWN) begin
            trk_pressed  = 1'b1;
            trk_dragging = 1'b0;
            trk_released = 1'b0;
            trk_dir      = DIR_NONE;
            trk_start_x  = x;
            trk_start_y  = y;
        end else if ((op == OP_MOVE || op == OP_UP) && trk_pressed) begin
            if (reach)
                trk_dragging = 1'b1;
            if (op == OP_UP) begin
                if (!reach)
                    trk_dir = DIR_NONE;
                else if ((ay << TAN_FRAC) <= ax * longint'(trk_tan))
                    trk_dir = (dx < 0) ? DIR_LEFT : DIR_RIGHT;
                else if ((ax << TAN_FRAC) <= ay * longint'(trk_tan))
                    trk_dir = (dy < 0) ? DIR_UP : DIR_DOWN;
                else
                    trk_dir = DIR_NONE;
                swipe_count[trk_dir]++;
                trk_pressed  = 1'b0;
                trk_released = 1'b1;
            end
        end
        marks.dir      = trk_dir;
        marks.pressed  = trk_pressed;
        marks.dragging = trk_dragging;
        marks.released = trk_released;
        return marks;
    endfunction

    function automatic stim_row_t event_row(logic [OP_W-1:0] op, int x, int y, logic typed,
                                            gesture_marks_t want);
        stim_row_t r;
        r.is_reg   = 1'b0;
        r.op       = op;
        r.x        = coord_t'(x);
        r.y        = coord_t'(y);
        r.typed    = typed;
        r.want     = want;
        r.reg_idx  = '0;
        r.reg_data = '0;
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int data);
        stim_row_t r;
        r.is_reg   = 1'b1;
        r.op       = OP_DOWN;
        r.x        = '0;
        r.y        = '0;
        r.typed    = 1'b0;
        r.want     = MARKS_IDLE;
        r.reg_idx  = idx;
        r.reg_data = CFG_DATA_W'(data);
        return r;
    endfunction

    function automatic int pick_offset(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_event(input logic [OP_W-1:0] op, input coord_t x, input coord_t y,
                              input logic typed, input gesture_marks_t want);
        gesture_marks_t marks;
        if (stall_on) begin
            while ($urandom_range(99) < 12) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_pos_x    <= x;
        i_pos_y    <= y;
        do @(posedge i_clk); while (!o_in_ready);
        sent_items++;
        if (op == OP_DOWN || ((op == OP_MOVE || op == OP_UP) && trk_pressed))
            live_items++;
        marks = track_gesture(op, x, y);
        pending_marks.push_back(typed ? want : marks);
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (pending_marks.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MIN_DIST)
            trk_min_dist = data[MIN_DIST_W-1:0];
        else
            trk_tan = data[TAN_W-1:0];
        cfg_writes++;
    endtask

    task automatic report_field(input string name, input int want, input int got);
        $display("%0t ERROR %s expected %0d got %0d", $time, name, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= !stall_on || ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin : result_check
        gesture_marks_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_marks.size() == 0) begin
                $display("%0t ERROR unexpected result: dir %0d pressed %0b dragging %0b released %0b",
                         $time, o_swipe_dir, o_is_pressed, o_is_dragging, o_is_released);
                errors++;
            end else begin
                want = pending_marks.pop_front();
                if (o_swipe_dir !== want.dir)
                    report_field("swipe_dir", want.dir, o_swipe_dir);
                if (o_is_pressed !== want.pressed)
                    report_field("is_pressed", want.pressed, o_is_pressed);
                if (o_is_dragging !== want.dragging)
                    report_field("is_dragging", want.dragging, o_is_dragging);
                if (o_is_released !== want.released)
                    report_field("is_released", want.released, o_is_released);
            end
        end
    end

    initial begin
        int phase, phase_goal, sel, span, sx, sy, dx, dy, d;
        logic held;
        logic [MIN_DIST_W-1:0] m;
        logic [TAN_W-1:0] t;

        // events while released, unused opcode, full-range corners
        directed_rows.push_back(event_row(OP_MOVE, 5, 5, 1'b1, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_UP, -3, 9, 1'b1, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_UNUSED, 16383, -16384, 1'b1, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_DOWN, 16383, -16384, 1'b1, MARKS_HELD));
        directed_rows.push_back(event_row(OP_MOVE, -16384, 16383, 1'b0, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_UP, -16384, 16383, 1'b0, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_DOWN, 0, 0, 1'b1, MARKS_HELD));
        directed_rows.push_back(event_row(OP_UNUSED, -1, -1, 1'b1, MARKS_HELD));
        directed_rows.push_back(event_row(OP_UP, 0, 0, 1'b1, MARKS_LIFTED));
        // drag threshold, left and down swipes
        directed_rows.push_back(event_row(OP_DOWN, 0, 0, 1'b1, MARKS_HELD));
        directed_rows.push_back(event_row(OP_MOVE, 15, 0, 1'b0, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_MOVE, 16, 0, 1'b0, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_UP, -20, 3, 1'b0, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_DOWN, 100, 100, 1'b1, MARKS_HELD));
        directed_rows.push_back(event_row(OP_UP, 100, 130, 1'b0, MARKS_IDLE));
        // restart with a second down while held
        directed_rows.push_back(event_row(OP_DOWN, 0, 0, 1'b1, MARKS_HELD));
        directed_rows.push_back(event_row(OP_MOVE, 50, 0, 1'b0, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_DOWN, 50, 0, 1'b1, MARKS_HELD));
        directed_rows.push_back(event_row(OP_UP, 55, 0, 1'b0, MARKS_IDLE));
        // zero minimum and zero tangent
        directed_rows.push_back(reg_row(CFG_MIN_DIST, 0));
        directed_rows.push_back(reg_row(CFG_TAN, 0));
        directed_rows.push_back(event_row(OP_DOWN, 7, 7, 1'b0, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_UP, 7, 7, 1'b0, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_DOWN, 0, 0, 1'b0, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_UP, 0, -1, 1'b0, MARKS_IDLE));
        // largest minimum and tangent
        directed_rows.push_back(reg_row(CFG_MIN_DIST, 4095));
        directed_rows.push_back(reg_row(CFG_TAN, 65535));
        directed_rows.push_back(event_row(OP_DOWN, -16384, -16384, 1'b0, MARKS_IDLE));
        directed_rows.push_back(event_row(OP_UP, 16383, 16383, 1'b0, MARKS_IDLE));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_reg)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
            else
                send_event(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                           directed_rows[i].typed, directed_rows[i].want);
        end

        live_items = 0;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin m = MIN_DIST_RST; t = TAN_RST; end
                1: begin m = '0; t = '0; end
                2: begin m = '1; t = '1; end
                3: begin m = 12'd8; t = 16'd16384; end
                4: begin m = '0; t = '1; end
                default: begin
                    m = ($urandom_range(3) == 0) ? MIN_DIST_W'($urandom_range(0, 4095))
                                                 : MIN_DIST_W'($urandom_range(0, 64));
                    t = TAN_W'($urandom_range(0, 65535));
                end
            endcase
            write_reg(CFG_MIN_DIST, CFG_DATA_W'(m));
            write_reg(CFG_TAN, CFG_DATA_W'(t));
            stall_on   = (phase != 5);
            held       = 1'b0;
            phase_goal = live_items + ITEMS_PER_PHASE;
            while (live_items < phase_goal) begin
                if (phase == 7 && !held && live_items >= phase_goal - ITEMS_PER_PHASE / 2) begin
                    wait_results();
                    held = 1'b1;
                end
                if ($urandom_range(99) < 80) begin
                    sel  = $urandom_range(4);
                    span = (sel == 0 || 2 * trk_min_dist + 2 > 8191) ? 8191 : 2 * trk_min_dist + 2;
                    sx   = pick_offset(8000);
                    sy   = pick_offset(8000);
                    send_event(OP_DOWN, coord_t'(sx), coord_t'(sy), 1'b0, MARKS_IDLE);
                    repeat ($urandom_range(0, 4))
                        send_event(OP_MOVE, coord_t'(sx + pick_offset(span)),
                                   coord_t'(sy + pick_offset(span)), 1'b0, MARKS_IDLE);
                    case (sel)
                        2: begin
                            d = ($urandom_range(1) == 0) ? int'(trk_min_dist) : -int'(trk_min_dist);
                            if ($urandom_range(1) == 0) begin
                                dx = d; dy = 0;
                            end else begin
                                dx = 0; dy = d;
                            end
                        end
                        3: begin
                            dx = pick_offset(span);
                            dy = ($urandom_range(1) == 0) ? dx : -dx;
                        end
                        default: begin
                            dx = pick_offset(span);
                            dy = pick_offset(span);
                        end
                    endcase
                    send_event(OP_UP, coord_t'(sx + dx), coord_t'(sy + dy), 1'b0, MARKS_IDLE);
                end else begin
                    send_event(OP_W'($urandom_range(0, 3)), coord_t'($urandom_range(0, 32767)),
                               coord_t'($urandom_range(0, 32767)), 1'b0, MARKS_IDLE);
                end
            end
        end

        wait_results();
        stall_on = 1'b0;
        repeat (8) @(posedge i_clk);
        $display("Ran %0d items, %0d of them acting on a gesture, across %0d register writes",
                 sent_items, live_items, cfg_writes);
        $display("Releases classified: none %0d, left %0d, right %0d, up %0d, down %0d",
                 swipe_count[DIR_NONE], swipe_count[DIR_LEFT], swipe_count[DIR_RIGHT],
                 swipe_count[DIR_UP], swipe_count[DIR_DOWN]);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
